@@ rtl/csem_pkg.sv @@
// Shared types and codes for the counting semaphore with priority wake.
`default_nettype none
package csem_pkg;

  typedef enum logic [1:0] {
    ACT_PEND   = 2'd0,
    ACT_POST   = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_GRANTED   = 3'd0,
    STS_BLOCKED   = 3'd1,
    STS_RAISED    = 3'd2,
    STS_WOKEN     = 3'd3,
    STS_CANCELLED = 3'd4,
    STS_NOT_FOUND = 3'd5,
    STS_ALREADY   = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  localparam int unsigned CountW  = 16;
  localparam int unsigned TaskIdW = 4;
  localparam int unsigned PrioInW = 8;

  // Control from the sequencer to the best-waiter compare unit.
  typedef struct packed {
    logic clear;
    logic cmp_en;
  } sel_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/counting_semaphore_priority_wake.sv @@
// Flow: pend, cancel, no-op and a post without waiters go from accept straight to the done state,
// where the result is registered once the output is free. A post with waiters first scans every
// task slot and passes the drain state, through the one compare unit that visits one slot per cycle.
// A new item is accepted only in the idle state, after the last result has been registered.
// Reset: count and waiter set clear, order matrix clears, max_count becomes 1;
// the priority memory is not cleared and its entries are used only for waiting tasks.
`default_nettype none
module counting_semaphore_priority_wake #(
  parameter int unsigned NUM_TASKS     = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_max_count_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [3:0]  task_id_i,
  input  wire logic [7:0]  task_priority_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic             woken_valid_o,
  output logic [3:0]       woken_task_o,
  output logic [15:0]      count_now_o
);

  localparam int unsigned IdxW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CntW  = csem_pkg::CountW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TASKS - 1);

  csem_pkg::state_e state_q, state_d;

  logic [CntW-1:0]          max_count_q;
  logic [CntW-1:0]          count_q, count_d;
  logic [NUM_TASKS-1:0]     wait_q, wait_d;
  logic [NUM_TASKS-1:0]     newer_q [NUM_TASKS];
  logic [NUM_TASKS-1:0]     newer_d [NUM_TASKS];

  csem_pkg::action_e        act_q;
  logic [csem_pkg::TaskIdW-1:0] tid_q;
  logic [PRIORITY_BITS-1:0] prio_q;

  logic [IdxW-1:0]          scan_q;
  logic                     cmp_vld_q;
  logic [IdxW-1:0]          cmp_idx_q;

  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [IdxW-1:0]          best_idx;
  csem_pkg::sel_ctrl_t      sel_ctrl;

  logic                     in_fire;
  logic                     fire;
  logic                     tid_ok;
  logic [IdxW-1:0]          tidx;
  logic                     tid_waiting;
  logic                     add_en;
  logic                     drop_en;
  logic [IdxW-1:0]          drop_idx;
  csem_pkg::status_e        status_d;
  logic                     woken_d;

  logic                     out_valid_q;
  csem_pkg::status_e        status_q;
  logic                     woken_valid_q;
  logic [3:0]               woken_task_q;
  logic [CntW-1:0]          count_now_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == csem_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign fire        = (state_q == csem_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csem_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((csem_pkg::action_e'(action_i) == csem_pkg::ACT_POST) && (|wait_q)) begin
            state_d = csem_pkg::S_SCAN;
          end else begin
            state_d = csem_pkg::S_DONE;
          end
        end
      end
      csem_pkg::S_SCAN: begin
        if (scan_q == LastIdx) begin
          state_d = csem_pkg::S_DRAIN;
        end
      end
      csem_pkg::S_DRAIN: state_d = csem_pkg::S_DONE;
      csem_pkg::S_DONE: begin
        if (fire) begin
          state_d = csem_pkg::S_IDLE;
        end
      end
      default: state_d = csem_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csem_pkg::S_IDLE;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == csem_pkg::S_SCAN);
      if (in_fire) begin
        scan_q <= '0;
      end else if (state_q == csem_pkg::S_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_q;
    if (in_fire) begin
      act_q  <= csem_pkg::action_e'(action_i);
      tid_q  <= task_id_i;
      prio_q <= task_priority_i[PRIORITY_BITS-1:0];
    end
  end

  csem_prio_mem #(
    .Depth (NUM_TASKS),
    .AddrW (IdxW),
    .DataW (PRIORITY_BITS)
  ) u_prio_mem (
    .clk_i   (clk_i),
    .we_i    (fire && add_en),
    .waddr_i (tidx),
    .wdata_i (prio_q),
    .re_i    (state_q == csem_pkg::S_SCAN),
    .raddr_i (scan_q),
    .rdata_o (rd_prio)
  );

  assign sel_ctrl.clear  = in_fire;
  assign sel_ctrl.cmp_en = cmp_vld_q && wait_q[cmp_idx_q];

  csem_sel #(
    .NumTasks (NUM_TASKS),
    .IdxW     (IdxW),
    .PrioW    (PRIORITY_BITS)
  ) u_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sel_ctrl),
    .cand_idx_i  (cmp_idx_q),
    .cand_prio_i (rd_prio),
    .cand_row_i  (newer_q[cmp_idx_q]),
    .best_idx_o  (best_idx)
  );

  // Operation decode in the final step
  always_comb begin
    tid_ok      = ({28'd0, tid_q} < NUM_TASKS);
    tidx        = IdxW'(tid_q);
    tid_waiting = tid_ok && wait_q[tidx];
    count_d     = count_q;
    add_en      = 1'b0;
    drop_en     = 1'b0;
    drop_idx    = tidx;
    woken_d     = 1'b0;
    status_d    = csem_pkg::STS_NOT_FOUND;
    unique case (act_q)
      csem_pkg::ACT_PEND: begin
        if (tid_waiting) begin
          status_d = csem_pkg::STS_ALREADY;
        end else if (count_q != '0) begin
          count_d  = count_q - 1'b1;
          status_d = csem_pkg::STS_GRANTED;
        end else begin
          add_en   = tid_ok;
          status_d = csem_pkg::STS_BLOCKED;
        end
      end
      csem_pkg::ACT_POST: begin
        if (wait_q == '0) begin
          if (count_q < max_count_q) begin
            count_d = count_q + 1'b1;
          end
          status_d = csem_pkg::STS_RAISED;
        end else begin
          drop_en  = 1'b1;
          drop_idx = best_idx;
          woken_d  = 1'b1;
          status_d = csem_pkg::STS_WOKEN;
        end
      end
      csem_pkg::ACT_CANCEL: begin
        if (tid_waiting) begin
          drop_en  = 1'b1;
          status_d = csem_pkg::STS_CANCELLED;
        end
      end
      default: status_d = csem_pkg::STS_NOT_FOUND;
    endcase
  end

  // Waiter set and pend-order matrix: bit j of row i set when j pended after i.
  always_comb begin
    wait_d = wait_q;
    for (int i = 0; i < NUM_TASKS; i++) begin
      newer_d[i] = newer_q[i];
      if (add_en && wait_q[i]) begin
        newer_d[i][tidx] = 1'b1;
      end
      if (drop_en) begin
        newer_d[i][drop_idx] = 1'b0;
      end
    end
    if (add_en) begin
      newer_d[tidx] = '0;
      wait_d[tidx]  = 1'b1;
    end
    if (drop_en) begin
      newer_d[drop_idx] = '0;
      wait_d[drop_idx]  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= CntW'(1);
      count_q     <= '0;
      wait_q      <= '0;
      newer_q     <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_count_q <= cfg_max_count_i;
      end
      if (fire) begin
        count_q     <= count_d;
        wait_q      <= wait_d;
        newer_q     <= newer_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q      <= status_d;
      woken_valid_q <= woken_d;
      woken_task_q  <= woken_d ? 4'(best_idx) : 4'd0;
      count_now_q   <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign woken_valid_o = woken_valid_q;
  assign woken_task_o  = woken_task_q;
  assign count_now_o   = count_now_q;

`ifndef ASSERT_OFF
  a_woken_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && woken_valid_o |-> status_o == csem_pkg::STS_WOKEN)
    else $error("woken result without woken status");

  a_best_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csem_pkg::S_DONE) && (act_q == csem_pkg::ACT_POST) && (|wait_q)
      |-> wait_q[best_idx])
    else $error("selected waiter is not waiting");

  a_woken_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && woken_d |=> !wait_q[$past(best_idx)])
    else $error("woken task still in waiter set");

  a_scan_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> !in_ready_o)
    else $error("input ready during waiter scan");
`endif

endmodule
`default_nettype wire

@@ rtl/csem_prio_mem.sv @@
// Waiter priority memory: one write port, one registered read port.
`default_nettype none
module csem_prio_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/csem_sel.sv @@
// Shared compare unit: keeps the best waiter seen so far during a scan.
`default_nettype none
module csem_sel #(
  parameter int unsigned NumTasks = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned PrioW    = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire csem_pkg::sel_ctrl_t  ctrl_i,
  input  wire logic [IdxW-1:0]      cand_idx_i,
  input  wire logic [PrioW-1:0]     cand_prio_i,
  input  wire logic [NumTasks-1:0]  cand_row_i,
  output logic      [IdxW-1:0]      best_idx_o
);

  logic                have_q, have_d;
  logic [IdxW-1:0]     best_idx_q;
  logic [PrioW-1:0]    best_prio_q;
  logic [NumTasks-1:0] best_row_q;
  logic                take;

  // Candidate wins on higher priority, or on a tie when it pended after the best.
  always_comb begin
    take = ctrl_i.cmp_en &&
           (!have_q || (cand_prio_i > best_prio_q) ||
            ((cand_prio_i == best_prio_q) && best_row_q[cand_idx_i]));
    have_d = ctrl_i.clear ? 1'b0 : (have_q || take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clear) begin
      best_idx_q  <= cand_idx_i;
      best_prio_q <= cand_prio_i;
      best_row_q  <= cand_row_i;
    end
  end

  assign best_idx_o = best_idx_q;

endmodule
`default_nettype wire
